/* rtl/core/rcre_pkg.sv */
// Package for the range condition rule engine.
// Holds sizes, action and command codes, store entry and item types.
// No dependencies.
package rcre_pkg;

  localparam int MAX_RULES      = 8;
  localparam int CONDS_PER_RULE = 8;
  localparam int ACTS_PER_RULE  = 8;
  localparam int NUM_CHANNELS   = 16;
  localparam int MAX_OUT        = 64;

  localparam int RULE_W = 3;
  localparam int SLOT_W = 3;
  localparam int CNT_W  = 4;
  localparam int CH_W   = 4;
  localparam int ADDR_W = RULE_W + SLOT_W;
  localparam int N_W    = 7;

  localparam int BYTE_CH_END  = 8;
  localparam int BIT_CH_END   = 10;
  localparam int PULSE_CH_END = 12;

  localparam logic [2:0] ACT_SAMPLE = 3'd0;
  localparam logic [2:0] ACT_COND   = 3'd1;
  localparam logic [2:0] ACT_DRIVE  = 3'd2;
  localparam logic [2:0] ACT_COUNTS = 3'd3;
  localparam logic [2:0] ACT_EVAL   = 3'd4;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_BIT   = 2'd1;
  localparam logic [1:0] KIND_PULSE = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  rule_index;
    logic [2:0]  slot;
    logic [3:0]  channel;
    logic [7:0]  sample;
    logic [7:0]  low_bound;
    logic [7:0]  high_bound;
    logic [15:0] drive_value;
    logic [3:0]  condition_count;
    logic [3:0]  actuator_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  command_kind;
    logic [3:0]  out_channel;
    logic [15:0] out_value;
    logic [2:0]  source_rule;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [CH_W-1:0] chan;
    logic [7:0]      low;
    logic [7:0]      high;
  } cond_t;

  typedef struct packed {
    logic [CH_W-1:0] chan;
    logic [15:0]     value;
  } act_t;

  localparam result_t NO_ACTION = '{
    command_kind: KIND_NONE,
    out_channel:  4'd0,
    out_value:    16'd0,
    source_rule:  3'd0,
    last:         1'b1
  };

endpackage

/* rtl/core/rcre_if.sv */
// Valid/ready channel interfaces for input items and results.
// Depends on rcre_pkg.
interface rcre_in_if import rcre_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rcre_out_if import rcre_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/rcre_act_map.sv */
// Maps one actuator entry to a command: byte, bit or pulse, or skip.
// Depends on rcre_pkg.
module rcre_act_map import rcre_pkg::*; (
  input  act_t              entry,
  input  logic [RULE_W-1:0] rule,
  output result_t           cmd,
  output logic              skip
);

  always_comb begin
    cmd.out_channel = entry.chan;
    cmd.source_rule = rule;
    cmd.last        = 1'b0;
    skip            = 1'b0;
    if (entry.chan < CH_W'(BYTE_CH_END)) begin
      cmd.command_kind = KIND_BYTE;
      cmd.out_value    = {8'd0, entry.value[7:0]};
    end else if (entry.chan < CH_W'(BIT_CH_END)) begin
      cmd.command_kind = KIND_BIT;
      cmd.out_value    = {8'd0, entry.value[7:0]};
    end else if (entry.chan < CH_W'(PULSE_CH_END)) begin
      cmd.command_kind = KIND_PULSE;
      cmd.out_value    = entry.value;
    end else begin
      cmd.command_kind = KIND_NONE;
      cmd.out_value    = entry.value;
      skip             = 1'b1;
    end
  end

endmodule

/* rtl/core/range_condition_rule_engine_core.sv */
// Range condition rule engine: top level with stores, sequencer and APB register.
// Load items write the sample, condition, actuator or count stores. An evaluate walks the
// active rules in order: each rule reads its conditions and stops at the first that fails;
// if all pass, each actuator entry is mapped to a command, up to 64 results in all, and
// output stalls hold the walk. One item at a time; the next item is taken once the walk ends.
// Reset clears samples, rule counts and active_rules; condition and actuator memories are not.
module range_condition_rule_engine_core import rcre_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  rcre_in_if.sink     in_ch,
  rcre_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RULE = 3'd1;
  localparam logic [2:0] S_COND = 3'd2;
  localparam logic [2:0] S_ACT  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]       state;
  logic [CNT_W-1:0] active_rules;
  logic [7:0]       sample_store [NUM_CHANNELS];
  logic [CNT_W-1:0] rule_conds [MAX_RULES];
  logic [CNT_W-1:0] rule_acts [MAX_RULES];
  cond_t            cond_mem [MAX_RULES*CONDS_PER_RULE];
  act_t             act_mem [MAX_RULES*ACTS_PER_RULE];
  cond_t            cond_rd;
  act_t             act_rd;

  logic [CNT_W-1:0] r;
  logic [CNT_W-1:0] cidx;
  logic [CNT_W-1:0] aidx;
  logic             pend;
  logic [N_W-1:0]   n;
  result_t          hold;
  logic             hold_valid;
  result_t          out_data;
  logic             out_valid;

  in_item_t         item;
  logic             in_fire;
  logic [CNT_W-1:0] nrules;
  logic [CNT_W-1:0] cond_cnt;
  logic [CNT_W-1:0] act_cnt;
  logic [7:0]       cur_sample;
  logic             cond_pass;
  result_t          act_cmd;
  logic             act_skip;
  logic             can_emit;
  logic             fin_go;
  logic             out_load;
  logic             cfg_wr;

  assign item      = in_ch.data;
  assign in_ch.ready = (state == S_IDLE);
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {28'd0, active_rules};

  assign nrules     = (active_rules > CNT_W'(MAX_RULES)) ? CNT_W'(MAX_RULES) : active_rules;
  assign cond_cnt   = rule_conds[r[RULE_W-1:0]];
  assign act_cnt    = rule_acts[r[RULE_W-1:0]];
  assign cur_sample = sample_store[cond_rd.chan];
  assign cond_pass  = (cur_sample >= cond_rd.low) && (cur_sample <= cond_rd.high);
  assign can_emit   = !hold_valid || !out_valid || out_ch.ready;
  assign fin_go     = !out_valid || out_ch.ready;
  assign out_load   = (state == S_EMIT && !act_skip && can_emit && hold_valid) ||
                      (state == S_FIN && fin_go);

  rcre_act_map u_act_map (
    .entry (act_rd),
    .rule  (r[RULE_W-1:0]),
    .cmd   (act_cmd),
    .skip  (act_skip)
  );

  always_ff @(posedge clk) begin
    if (in_fire && item.action == ACT_COND) begin
      cond_mem[{item.rule_index, item.slot}] <= '{
        chan: item.channel, low: item.low_bound, high: item.high_bound};
    end
    cond_rd <= cond_mem[{r[RULE_W-1:0], cidx[SLOT_W-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (in_fire && item.action == ACT_DRIVE) begin
      act_mem[{item.rule_index, item.slot}] <= '{chan: item.channel, value: item.drive_value};
    end
    act_rd <= act_mem[{r[RULE_W-1:0], aidx[SLOT_W-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_rules <= '0;
    end else if (cfg_wr) begin
      active_rules <= pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) sample_store[i] <= 8'd0;
      for (int i = 0; i < MAX_RULES; i++) begin
        rule_conds[i] <= '0;
        rule_acts[i]  <= '0;
      end
    end else if (in_fire) begin
      if (item.action == ACT_SAMPLE) begin
        sample_store[item.channel] <= item.sample;
      end
      if (item.action == ACT_COUNTS) begin
        rule_conds[item.rule_index] <= (item.condition_count > CNT_W'(CONDS_PER_RULE)) ?
                                       CNT_W'(CONDS_PER_RULE) : item.condition_count;
        rule_acts[item.rule_index]  <= (item.actuator_count > CNT_W'(ACTS_PER_RULE)) ?
                                       CNT_W'(ACTS_PER_RULE) : item.actuator_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      r          <= '0;
      cidx       <= '0;
      aidx       <= '0;
      pend       <= 1'b0;
      n          <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_ch.ready && !out_load) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_fire && item.action == ACT_EVAL) begin
            r          <= '0;
            n          <= '0;
            hold_valid <= 1'b0;
            state      <= S_RULE;
          end
        end
        S_RULE: begin
          if (r >= nrules || n == N_W'(MAX_OUT)) begin
            state <= S_FIN;
          end else begin
            cidx  <= '0;
            pend  <= 1'b0;
            state <= S_COND;
          end
        end
        S_COND: begin
          if (pend && !cond_pass) begin
            pend  <= 1'b0;
            r     <= r + 1'b1;
            state <= S_RULE;
          end else if (cidx < cond_cnt) begin
            cidx <= cidx + 1'b1;
            pend <= 1'b1;
          end else if (pend) begin
            pend <= 1'b0;
          end else begin
            aidx  <= '0;
            state <= S_ACT;
          end
        end
        S_ACT: begin
          if (aidx >= act_cnt || n == N_W'(MAX_OUT)) begin
            r     <= r + 1'b1;
            state <= S_RULE;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (act_skip) begin
            aidx  <= aidx + 1'b1;
            state <= S_ACT;
          end else if (can_emit) begin
            if (hold_valid) begin
              out_data  <= hold;
              out_valid <= 1'b1;
            end
            hold       <= act_cmd;
            hold_valid <= 1'b1;
            n          <= n + 1'b1;
            aidx       <= aidx + 1'b1;
            state      <= S_ACT;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            if (hold_valid) begin
              out_data <= '{
                command_kind: hold.command_kind,
                out_channel:  hold.out_channel,
                out_value:    hold.out_value,
                source_rule:  hold.source_rule,
                last:         1'b1
              };
            end else begin
              out_data <= NO_ACTION;
            end
            out_valid  <= 1'b1;
            hold_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_n_bound: assert property (@(posedge clk) disable iff (rst)
    n <= N_W'(MAX_OUT))
    else $error("result count beyond limit");

  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !hold_valid)
    else $error("held result left over after evaluate");

  a_fin_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && fin_go) |=> (out_valid && out_data.last))
    else $error("final transfer not marked last");

endmodule

/* test/testbench.sv */
// Self-checking bench for range_condition_rule_engine_core: directed tables, then random traffic.
// Predicts the command stream per evaluate and compares each result transfer in order.
// Depends on rcre_pkg, rcre_in_if, rcre_out_if and the core RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rcre_pkg::*;

  localparam logic [2:0] REG_ACTIVE_RULES = 3'd0;
  localparam int RANDOM_ITEMS  = 460;
  localparam int SETTLE_CYCLES = 32;
  localparam int DRAIN_CYCLES  = 300;
  localparam int RUN_LIMIT     = 4000000;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rcre_in_if  in_ch ();
  rcre_out_if out_ch ();

  range_condition_rule_engine_core dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [7:0]  samples [NUM_CHANNELS];
  cond_t       conds [MAX_RULES][CONDS_PER_RULE];
  act_t        acts [MAX_RULES][ACTS_PER_RULE];
  bit          cond_written [MAX_RULES][CONDS_PER_RULE];
  bit          act_written [MAX_RULES][ACTS_PER_RULE];
  logic [3:0]  n_conds [MAX_RULES];
  logic [3:0]  n_acts [MAX_RULES];
  logic [3:0]  active_rules_cfg;
  result_t     pending_cmds [$];

  int          error_count;
  int unsigned cycle_count;
  int          src_idle_pct;
  int          rcv_stall_pct;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    error_count++;
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    result_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_cmds.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d channel %0d value %h",
                                  got.command_kind, got.out_channel, got.out_value));
      end else begin
        want = pending_cmds.pop_front();
        if (got.command_kind !== want.command_kind)
          report_mismatch($sformatf("command_kind got %0d want %0d",
                                    got.command_kind, want.command_kind));
        if (got.out_channel !== want.out_channel)
          report_mismatch($sformatf("out_channel got %0d want %0d",
                                    got.out_channel, want.out_channel));
        if (got.out_value !== want.out_value)
          report_mismatch($sformatf("out_value got %h want %h", got.out_value, want.out_value));
        if (got.source_rule !== want.source_rule)
          report_mismatch($sformatf("source_rule got %0d want %0d",
                                    got.source_rule, want.source_rule));
        if (got.last !== want.last)
          report_mismatch($sformatf("last got %b want %b", got.last, want.last));
      end
    end
  end

  function automatic void reset_tables();
    for (int r = 0; r < MAX_RULES; r++) begin
      n_conds[r] = '0;
      n_acts[r]  = '0;
      for (int s = 0; s < CONDS_PER_RULE; s++) cond_written[r][s] = 1'b0;
      for (int s = 0; s < ACTS_PER_RULE; s++) act_written[r][s] = 1'b0;
    end
    for (int c = 0; c < NUM_CHANNELS; c++) samples[c] = '0;
    active_rules_cfg = '0;
  endfunction

  function automatic void predict_commands(input in_item_t item);
    result_t batch [$];
    result_t cmd;
    int      nrules;
    bit      fires;
    cond_t   cnd;
    act_t    act;
    case (item.action)
      ACT_SAMPLE: samples[item.channel] = item.sample;
      ACT_COND: begin
        cnd.chan = item.channel;
        cnd.low  = item.low_bound;
        cnd.high = item.high_bound;
        conds[item.rule_index][item.slot] = cnd;
        cond_written[item.rule_index][item.slot] = 1'b1;
      end
      ACT_DRIVE: begin
        act.chan  = item.channel;
        act.value = item.drive_value;
        acts[item.rule_index][item.slot] = act;
        act_written[item.rule_index][item.slot] = 1'b1;
      end
      ACT_COUNTS: begin
        n_conds[item.rule_index] = (item.condition_count > 4'(CONDS_PER_RULE)) ?
                                   4'(CONDS_PER_RULE) : item.condition_count;
        n_acts[item.rule_index]  = (item.actuator_count > 4'(ACTS_PER_RULE)) ?
                                   4'(ACTS_PER_RULE) : item.actuator_count;
      end
      ACT_EVAL: begin
        nrules = (active_rules_cfg > MAX_RULES) ? MAX_RULES : int'(active_rules_cfg);
        for (int r = 0; r < nrules && batch.size() < MAX_OUT; r++) begin
          fires = 1'b1;
          for (int j = 0; j < n_conds[r]; j++) begin
            cnd = conds[r][j];
            if (samples[cnd.chan] < cnd.low || samples[cnd.chan] > cnd.high) begin
              fires = 1'b0;
              break;
            end
          end
          if (!fires) continue;
          for (int j = 0; j < n_acts[r] && batch.size() < MAX_OUT; j++) begin
            act = acts[r][j];
            cmd.out_channel = act.chan;
            cmd.source_rule = r[2:0];
            cmd.last        = 1'b0;
            if (act.chan < BYTE_CH_END) begin
              cmd.command_kind = KIND_BYTE;
              cmd.out_value    = {8'd0, act.value[7:0]};
            end else if (act.chan < BIT_CH_END) begin
              cmd.command_kind = KIND_BIT;
              cmd.out_value    = {8'd0, act.value[7:0]};
            end else if (act.chan < PULSE_CH_END) begin
              cmd.command_kind = KIND_PULSE;
              cmd.out_value    = act.value;
            end else begin
              continue;
            end
            batch.push_back(cmd);
          end
        end
        if (batch.size() == 0) begin
          pending_cmds.push_back(NO_ACTION);
        end else begin
          batch[batch.size() - 1].last = 1'b1;
          foreach (batch[i]) pending_cmds.push_back(batch[i]);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int written_prefix(input int r, input bit for_acts);
    int n;
    n = 0;
    if (for_acts) begin
      while (n < ACTS_PER_RULE && act_written[r][n]) n++;
    end else begin
      while (n < CONDS_PER_RULE && cond_written[r][n]) n++;
    end
    return n;
  endfunction

  function automatic in_item_t noisy_item(input logic [2:0] action);
    in_item_t item;
    item.action          = action;
    item.rule_index      = 3'($urandom_range(0, 7));
    item.slot            = 3'($urandom_range(0, 7));
    item.channel         = 4'($urandom_range(0, 15));
    item.sample          = 8'($urandom_range(0, 255));
    item.low_bound       = 8'($urandom_range(0, 255));
    item.high_bound      = 8'($urandom_range(0, 255));
    item.drive_value     = 16'($urandom_range(0, 65535));
    item.condition_count = 4'($urandom_range(0, 15));
    item.actuator_count  = 4'($urandom_range(0, 15));
    return item;
  endfunction

  function automatic in_item_t random_item();
    in_item_t item;
    int       pick;
    int       prefix;
    int       level;
    int       lo;
    pick = int'($urandom_range(0, 99));
    if (pick < 3) begin
      item = noisy_item(3'($urandom_range(5, 7)));
    end else if (pick < 28) begin
      item = noisy_item(ACT_SAMPLE);
    end else if (pick < 53) begin
      item = noisy_item(ACT_COND);
      prefix = written_prefix(int'(item.rule_index), 1'b0);
      if (prefix < CONDS_PER_RULE && $urandom_range(0, 9) < 7) item.slot = 3'(prefix);
      level = int'(samples[item.channel]);
      pick = int'($urandom_range(0, 99));
      if (pick < 60) begin
        item.low_bound  = 8'($urandom_range(0, level));
        item.high_bound = 8'($urandom_range(level, 255));
      end else if (pick < 75) begin
        lo = int'($urandom_range(1, 255));
        item.low_bound  = 8'(lo);
        item.high_bound = 8'($urandom_range(0, lo - 1));
      end
    end else if (pick < 73) begin
      item = noisy_item(ACT_DRIVE);
      prefix = written_prefix(int'(item.rule_index), 1'b1);
      if (prefix < ACTS_PER_RULE && $urandom_range(0, 9) < 7) item.slot = 3'(prefix);
    end else if (pick < 88) begin
      item = noisy_item(ACT_COUNTS);
      prefix = written_prefix(int'(item.rule_index), 1'b0);
      item.condition_count = 4'((prefix == CONDS_PER_RULE) ? $urandom_range(0, 15) :
                                $urandom_range(0, prefix));
      prefix = written_prefix(int'(item.rule_index), 1'b1);
      item.actuator_count = 4'((prefix == ACTS_PER_RULE) ? $urandom_range(0, 15) :
                               $urandom_range(0, prefix));
    end else begin
      item = noisy_item(ACT_EVAL);
    end
    return item;
  endfunction

  task automatic send_item(input in_item_t item);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_commands(item);
  endtask

  task automatic wait_quiet(input int extra);
    in_ch.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic apb_transfer(input logic write, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_active_rules(input logic [3:0] value);
    logic [31:0] rdata;
    wait_quiet(SETTLE_CYCLES);
    apb_transfer(1'b1, REG_ACTIVE_RULES, {28'd0, value}, rdata);
    active_rules_cfg = value;
    apb_transfer(1'b0, REG_ACTIVE_RULES, '0, rdata);
    if (rdata !== {28'd0, value})
      report_mismatch($sformatf("active_rules read %h want %h", rdata, value));
  endtask

  task automatic test_register_access();
    set_active_rules(4'd15);
    set_active_rules(4'd0);
  endtask

  task automatic test_empty_tables();
    send_item(noisy_item(ACT_EVAL));
    set_active_rules(4'd15);
    send_item(noisy_item(ACT_EVAL));
  endtask

  task automatic test_command_kinds();
    logic [3:0]  chans [ACTS_PER_RULE] = '{4'd0, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd15};
    logic [15:0] vals [ACTS_PER_RULE] = '{16'hFFFF, 16'h00A5, 16'h0100, 16'h00FF,
                                          16'hFFFF, 16'h0000, 16'h1234, 16'h8001};
    in_item_t item;
    for (int s = 0; s < ACTS_PER_RULE; s++) begin
      item = noisy_item(ACT_DRIVE);
      item.rule_index  = 3'd0;
      item.slot        = s[2:0];
      item.channel     = chans[s];
      item.drive_value = vals[s];
      send_item(item);
    end
    item = noisy_item(ACT_COUNTS);
    item.rule_index      = 3'd0;
    item.condition_count = 4'd0;
    item.actuator_count  = 4'd15;
    send_item(item);
    send_item(noisy_item(ACT_EVAL));
  endtask

  task automatic write_condition(input logic [2:0] slot, input logic [3:0] chan,
                                 input logic [7:0] low, input logic [7:0] high);
    in_item_t item;
    item = noisy_item(ACT_COND);
    item.rule_index = 3'd1;
    item.slot       = slot;
    item.channel    = chan;
    item.low_bound  = low;
    item.high_bound = high;
    send_item(item);
  endtask

  task automatic test_range_bounds();
    in_item_t item;
    item = noisy_item(ACT_SAMPLE);
    item.channel = 4'd3;
    item.sample  = 8'd0;
    send_item(item);
    item = noisy_item(ACT_SAMPLE);
    item.channel = 4'd15;
    item.sample  = 8'd255;
    send_item(item);
    write_condition(3'd0, 4'd3, 8'd0, 8'd0);
    write_condition(3'd1, 4'd15, 8'd255, 8'd255);
    write_condition(3'd2, 4'd3, 8'd0, 8'd255);
    item = noisy_item(ACT_DRIVE);
    item.rule_index  = 3'd1;
    item.slot        = 3'd0;
    item.channel     = 4'd9;
    item.drive_value = 16'hABCD;
    send_item(item);
    item = noisy_item(ACT_COUNTS);
    item.rule_index      = 3'd1;
    item.condition_count = 4'd3;
    item.actuator_count  = 4'd1;
    send_item(item);
    send_item(noisy_item(ACT_EVAL));
    write_condition(3'd3, 4'd15, 8'd200, 8'd100);
    item.condition_count = 4'd4;
    send_item(item);
    send_item(noisy_item(ACT_EVAL));
  endtask

  task automatic test_unused_actions();
    send_item(noisy_item(3'd5));
    send_item(noisy_item(3'd6));
    send_item(noisy_item(3'd7));
  endtask

  task automatic test_random_traffic();
    in_item_t   item;
    int         accepted;
    logic [3:0] setting;
    for (int phase = 0; phase < 3; phase++) begin
      for (int seg = 0; seg < 2; seg++) begin
        case (phase * 2 + seg)
          0:       setting = 4'd8;
          1:       setting = 4'd15;
          2:       setting = 4'($urandom_range(1, 7));
          3:       setting = 4'd12;
          4:       setting = 4'd8;
          default: setting = 4'($urandom_range(1, 8));
        endcase
        set_active_rules(setting);
        src_idle_pct  = (phase == 0) ? 9 : (phase == 1) ? 74 : 0;
        rcv_stall_pct = (phase == 0) ? 74 : (phase == 1) ? 9 : 0;
        accepted = 0;
        while (accepted < (RANDOM_ITEMS + 5) / 6) begin
          item = random_item();
          send_item(item);
          accepted++;
        end
      end
    end
  endtask

  initial begin
    error_count   = 0;
    src_idle_pct  = 9;
    rcv_stall_pct = 74;
    reset_tables();
    rst          <= 1'b1;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_access();
    test_empty_tables();
    test_command_kinds();
    test_range_bounds();
    test_unused_actions();
    test_random_traffic();
    wait_quiet(DRAIN_CYCLES);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/rcre_pkg.sv
rtl/core/rcre_if.sv
rtl/core/rcre_act_map.sv
rtl/core/range_condition_rule_engine_core.sv
test/testbench.sv
